>>> rtl/core/stereo_ring_mixer_with_gain_macros.svh
// Assertion macros used by the stereo ring mixer RTL.
// Needs nothing else; define NO_ASSERTIONS to compile the checks out.
`ifndef STEREO_RING_MIXER_WITH_GAIN_MACROS_SVH
`define STEREO_RING_MIXER_WITH_GAIN_MACROS_SVH
`ifndef NO_ASSERTIONS
// Antecedent and consequent in the same cycle.
`define SRMG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Consequent in the cycle after the antecedent.
`define SRMG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SRMG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define SRMG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/srmg_pkg.sv
// Types and constants of the stereo ring mixer with master gain.
// Used by srmg_gain and stereo_ring_mixer_with_gain; depends on nothing.
package srmg_pkg;

   typedef enum logic [1:0] {
      CMD_MIX       = 2'd0,
      CMD_OVERWRITE = 2'd1,
      CMD_READ      = 2'd2,
      CMD_CLEAR     = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      REG_MASTER_VOLUME = 1'b0,
      REG_MUTE          = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_GAIN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic               start_req;
      logic [11:0]        frame_index;
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
      logic               last_in;
   } req_type;

   typedef struct packed {
      logic [11:0]        position;
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               last_out;
   } rsp_type;

   // Stage enables of the gain unit.
   typedef struct packed {
      logic load;
      logic quot;
      logic fix;
   } gain_ctrl_type;

   localparam logic [6:0]         VOL_MAX    = 7'd100;
   localparam int                 GAIN_DIV   = 100;
   localparam int                 GAIN_SHIFT = 30;
   // floor(2^30 / 100); the estimate it gives is at most one below the quotient.
   localparam logic [23:0]        GAIN_RECIP = 24'd10737418;
   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

endpackage

>>> rtl/core/srmg_gain.sv
// Gain unit: one sample times the applied volume, divided by 100 toward zero.
// Three enabled stages; uses srmg_pkg for the control struct and constants.
module srmg_gain (
   input  logic                    clock,
   input  srmg_pkg::gain_ctrl_type ctrl,
   input  logic signed [15:0]      sample,
   input  logic [6:0]              volume,
   output logic signed [15:0]      gained
);

   logic signed [7:0]  vol_s;
   logic signed [23:0] prod_full;
   logic               neg_in;
   logic               neg_ff;
   logic [21:0]        mag_in;
   logic [21:0]        mag_ff;
   logic [45:0]        qprod;
   logic [15:0]        quot_in;
   logic [15:0]        quot_ff;
   logic [21:0]        rem;
   logic [15:0]        quot_fix;
   logic signed [15:0] gained_in;
   logic signed [15:0] gained_ff;

   assign vol_s     = $signed({1'b0, volume});
   assign prod_full = sample * vol_s;
   assign neg_in    = prod_full[23];
   assign mag_in    = neg_in ? 22'(-prod_full) : prod_full[21:0];

   assign qprod   = 46'(mag_ff) * 46'(srmg_pkg::GAIN_RECIP);
   assign quot_in = qprod[srmg_pkg::GAIN_SHIFT +: 16];

   // The estimate is never above the true quotient, so one correction suffices.
   assign rem       = mag_ff - 22'(32'(quot_ff) * 32'(srmg_pkg::GAIN_DIV));
   assign quot_fix  = (rem >= 22'(srmg_pkg::GAIN_DIV)) ? quot_ff + 16'd1 : quot_ff;
   assign gained_in = $signed(neg_ff ? 16'(-quot_fix) : quot_fix);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (ctrl.quot) begin
         quot_ff <= quot_in;
      end
      if (ctrl.fix) begin
         gained_ff <= gained_in;
      end
   end

   assign gained = gained_ff;

endmodule

>>> rtl/core/stereo_ring_mixer_with_gain.sv
// Stereo ring mixer: master gain, then mix, overwrite, read or clear of one ring frame.
// Depends on srmg_pkg, srmg_gain and stereo_ring_mixer_with_gain_macros.svh.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | srmg_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | srmg_pkg::rsp_type
//   apb     | in/out    | psel/penable/pready | paddr, pwdata, prdata
//
// A transaction passes through accept, address and position reduction, gain
// correction, then the read-modify-write of the ring memory, whose read data is
// registered. After reset the ring is swept to silence, one frame a cycle, with
// req_stall high; register writes are taken meanwhile.
// The result register lets the next transaction be accepted while a result waits;
// the write step holds while a result is still stalled.
`include "stereo_ring_mixer_with_gain_macros.svh"

module stereo_ring_mixer_with_gain #(
   parameter int RING_FRAMES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  srmg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output srmg_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int AW        = $clog2(RING_FRAMES);
   localparam int IDX_RECIP = (1 << 24) / RING_FRAMES;

   srmg_pkg::state_type     state_ff;
   srmg_pkg::state_type     state_in;
   srmg_pkg::gain_ctrl_type gain_ctrl;
   srmg_pkg::rsp_type       rsp_data_ff;
   srmg_pkg::rsp_type       rsp_data_in;

   logic              accept;
   logic              out_free;
   logic              mem_re;
   logic              mem_we;
   logic              rsp_load;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [6:0]        vol_ff;
   logic [6:0]        vol_in;
   logic              mute_ff;
   logic              mute_in;
   logic [6:0]        eff_vol;
   logic              cfg_write;
   logic [AW-1:0]     clr_ff;
   logic [AW-1:0]     clr_in;
   logic [AW-1:0]     wp_ff;
   logic [AW-1:0]     wp_in;
   logic [AW-1:0]     pos_ff;
   logic [AW-1:0]     pos_in;
   logic [AW-1:0]     mem_waddr;
   logic [31:0]       mem_wdata;
   logic [31:0]       rd_data_ff;
   logic [1:0]        cmd_ff;
   logic              start_ff;
   logic              last_ff;
   logic [11:0]       idx_ff;
   logic [35:0]       idx_prod;
   logic [11:0]       idx_q0_ff;
   logic [11:0]       idx_sub;
   logic [11:0]       idx_rem0;
   logic [11:0]       idx_rem;
   logic signed [15:0] gain_l;
   logic signed [15:0] gain_r;
   logic signed [15:0] st_l;
   logic signed [15:0] st_r;
   logic signed [15:0] new_l;
   logic signed [15:0] new_r;
   logic signed [16:0] sum_l;
   logic signed [16:0] sum_r;
   logic [31:0]       pos_wide;
   logic [31:0]       ring_mem [RING_FRAMES];

   function automatic logic signed [15:0] sat16(input logic signed [16:0] s);
      logic signed [15:0] r;
      if (s[16] != s[15]) begin
         r = s[16] ? srmg_pkg::SAMPLE_MIN : srmg_pkg::SAMPLE_MAX;
      end else begin
         r = s[15:0];
      end
      return r;
   endfunction

   // Configuration port.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      vol_in  = vol_ff;
      mute_in = mute_ff;
      if (cfg_write) begin
         unique case (srmg_pkg::reg_index_type'(paddr[2]))
            srmg_pkg::REG_MASTER_VOLUME: begin
               vol_in = (pwdata[6:0] > srmg_pkg::VOL_MAX) ? srmg_pkg::VOL_MAX : pwdata[6:0];
            end
            srmg_pkg::REG_MUTE: begin
               mute_in = pwdata[0];
            end
         endcase
      end
   end

   always_comb begin
      unique case (srmg_pkg::reg_index_type'(paddr[2]))
         srmg_pkg::REG_MASTER_VOLUME: prdata = {25'd0, vol_ff};
         srmg_pkg::REG_MUTE:          prdata = {31'd0, mute_ff};
      endcase
   end

   assign eff_vol = mute_ff ? 7'd0 : vol_ff;

   // Handshakes.
   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srmg_pkg::ST_CLEAR: begin
            if (32'(clr_ff) == RING_FRAMES - 1) begin
               state_in = srmg_pkg::ST_IDLE;
            end
         end
         srmg_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = srmg_pkg::ST_ADDR;
            end
         end
         srmg_pkg::ST_ADDR: state_in = srmg_pkg::ST_GAIN;
         srmg_pkg::ST_GAIN: state_in = srmg_pkg::ST_WRITE;
         srmg_pkg::ST_WRITE: begin
            if (out_free) begin
               state_in = srmg_pkg::ST_IDLE;
            end
         end
         default: state_in = srmg_pkg::ST_CLEAR;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall      = 1'b1;
      mem_re         = 1'b0;
      mem_we         = 1'b0;
      rsp_load       = 1'b0;
      gain_ctrl.load = 1'b0;
      gain_ctrl.quot = 1'b0;
      gain_ctrl.fix  = 1'b0;
      unique case (state_ff)
         srmg_pkg::ST_CLEAR: mem_we = 1'b1;
         srmg_pkg::ST_IDLE: begin
            req_stall      = 1'b0;
            gain_ctrl.load = req_valid;
         end
         srmg_pkg::ST_ADDR: begin
            mem_re         = 1'b1;
            gain_ctrl.quot = 1'b1;
         end
         srmg_pkg::ST_GAIN: gain_ctrl.fix = 1'b1;
         srmg_pkg::ST_WRITE: begin
            mem_we   = out_free;
            rsp_load = out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // Start position: frame_index modulo the ring size, by a reciprocal estimate
   // taken at accept and a single correcting subtract in the address cycle.
   assign idx_prod = 36'(req_data.frame_index) * 36'(IDX_RECIP);
   assign idx_sub  = 12'(32'(idx_q0_ff) * RING_FRAMES);
   assign idx_rem0 = idx_ff - idx_sub;
   assign idx_rem  = (32'(idx_rem0) >= RING_FRAMES) ? 12'(32'(idx_rem0) - RING_FRAMES)
                                                    : idx_rem0;
   assign pos_in   = start_ff ? AW'(idx_rem) : wp_ff;
   assign wp_in    = (32'(pos_ff) == RING_FRAMES - 1) ? '0 : pos_ff + 1'b1;
   assign clr_in   = clr_ff + 1'b1;

   srmg_gain u_gain_l (
      .clock  (clock),
      .ctrl   (gain_ctrl),
      .sample (req_data.left_in),
      .volume (eff_vol),
      .gained (gain_l)
   );

   srmg_gain u_gain_r (
      .clock  (clock),
      .ctrl   (gain_ctrl),
      .sample (req_data.right_in),
      .volume (eff_vol),
      .gained (gain_r)
   );

   // Modify step of the read-modify-write.
   assign st_l  = $signed(rd_data_ff[15:0]);
   assign st_r  = $signed(rd_data_ff[31:16]);
   assign sum_l = 17'(st_l) + 17'(gain_l);
   assign sum_r = 17'(st_r) + 17'(gain_r);

   always_comb begin
      unique case (srmg_pkg::cmd_type'(cmd_ff))
         srmg_pkg::CMD_MIX: begin
            new_l = sat16(sum_l);
            new_r = sat16(sum_r);
         end
         srmg_pkg::CMD_OVERWRITE: begin
            new_l = gain_l;
            new_r = gain_r;
         end
         srmg_pkg::CMD_READ: begin
            new_l = st_l;
            new_r = st_r;
         end
         srmg_pkg::CMD_CLEAR: begin
            new_l = '0;
            new_r = '0;
         end
      endcase
   end

   assign mem_waddr = (state_ff == srmg_pkg::ST_CLEAR) ? clr_ff : pos_ff;
   assign mem_wdata = (state_ff == srmg_pkg::ST_CLEAR) ? 32'd0 : {new_r, new_l};

   assign pos_wide              = 32'(pos_ff);
   assign rsp_data_in.position  = pos_wide[11:0];
   assign rsp_data_in.left_out  = new_l;
   assign rsp_data_in.right_out = new_r;
   assign rsp_data_in.last_out  = last_ff;

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // Ring memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[pos_in];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srmg_pkg::ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         vol_ff       <= srmg_pkg::VOL_MAX;
         mute_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vol_ff       <= vol_in;
         mute_ff      <= mute_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == srmg_pkg::ST_CLEAR) begin
            clr_ff <= clr_in;
         end
         if (rsp_load) begin
            wp_ff <= wp_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_data.cmd;
         start_ff  <= req_data.start_req;
         last_ff   <= req_data.last_in;
         idx_ff    <= req_data.frame_index;
         idx_q0_ff <= idx_prod[35:24];
      end
      if (mem_re) begin
         pos_ff <= pos_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SRMG_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == srmg_pkg::ST_ADDR, "accepted transaction did not start")
   `SRMG_ASSERT_SAME(a_wp_in_ring, clock, reset, 1'b1, 32'(wp_ff) < RING_FRAMES, "write position outside ring")
   `SRMG_ASSERT_SAME(a_pos_in_ring, clock, reset, state_ff == srmg_pkg::ST_WRITE, 32'(pos_ff) < RING_FRAMES, "frame position outside ring")
   `SRMG_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid_ff && rsp_stall, $stable(rsp_data_ff) && rsp_valid_ff, "waiting result overwritten")
   `SRMG_ASSERT_SAME(a_result_from_write, clock, reset, $rose(rsp_valid_ff), $past(state_ff == srmg_pkg::ST_WRITE), "result appeared outside write step")

endmodule
